FILE: rtl/union_find_maze_wall_remover_top_assert.svh
// ----------------------------------------------------------------------------
// union find maze wall remover assertion macros
// concurrent assertion helpers clocked on clk_i and disabled during reset
// ----------------------------------------------------------------------------
`ifndef UNION_FIND_MAZE_WALL_REMOVER_TOP_ASSERT_SVH
`define UNION_FIND_MAZE_WALL_REMOVER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// property that holds at every clock edge
`define UFM_ASSERT(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("ufmaze assertion failed");
// implication that the consequent holds in the cycle after the antecedent
`define UFM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ufmaze assertion failed");
`else
`define UFM_ASSERT(label, expr)
`define UFM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: rtl/ufmaze_pkg.sv
// ----------------------------------------------------------------------------
// ufmaze_pkg
// shared types, codes and constants of the union find maze wall remover
// ----------------------------------------------------------------------------
package ufmaze_pkg;

  localparam int CELL_W        = 11;
  localparam int SIDE_W        = 6;
  localparam int STATUS_W      = 3;
  localparam int WALL_W        = 12;
  localparam int MAX_SIDE_DEF  = 32;
  localparam int MAX_CELLS_DEF = 1024;
  localparam int RESET_SIDE    = 8;

  localparam logic [STATUS_W-1:0] STAT_REMOVED = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_EDGE    = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_JOINED  = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_DONE    = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_RANGE   = 3'd4;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_FREAD,
    ST_FWALK,
    ST_CWALK,
    ST_LINK,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    PH_CELL,
    PH_OTHER,
    PH_FIRST,
    PH_LAST
  } phase_e;

  // largest side whose square fits in the cell store
  function automatic int side_cap(input int max_side, input int max_cells);
    int s;
    s = (max_side < 2) ? 2 : max_side;
    while (s > 2 && s * s > max_cells) begin
      s = s - 1;
    end
    return s;
  endfunction

  function automatic int side_fit(input int side, input int cap);
    int s;
    s = (side > cap) ? cap : side;
    s = (s < 2) ? 2 : s;
    return s;
  endfunction

endpackage

FILE: rtl/ufmaze_ram.sv
// ----------------------------------------------------------------------------
// ufmaze_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
module ufmaze_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1025
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/union_find_maze_wall_remover_top.sv
// ----------------------------------------------------------------------------
// union_find_maze_wall_remover_top
// Randomized Kruskal maze builder over a square grid with a union find parent
// memory and full path compression. One request at a time: an item is accepted,
// checked, run through the remainder steps for an in-range right wall, then up
// to four root searches (read, walk to the root, compress the path), a link when
// the roots differ and a done state that hands over the result once the output
// is free; once the maze is done an item goes straight to the done state. The
// single read port of the parent memory sets the pace. After reset and every
// grid_side write the parent memory is reinitialized while no request is taken.
// ----------------------------------------------------------------------------
`include "union_find_maze_wall_remover_top_assert.svh"

module union_find_maze_wall_remover_top
  import ufmaze_pkg::*;
#(
  parameter int MAX_SIDE  = MAX_SIDE_DEF,
  parameter int MAX_CELLS = MAX_CELLS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [SIDE_W-1:0]   cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CELL_W-1:0]   cell_req_i,
  input  logic                toward_right_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [WALL_W-1:0]   wall_index_o,
  output logic                start_end_joined_o
);

  localparam int DEPTH    = MAX_CELLS + 1;
  localparam int AW       = $clog2(DEPTH);
  localparam int NW       = (AW > CELL_W) ? AW : CELL_W;
  localparam int SW       = $clog2(MAX_SIDE + 1);
  localparam int GW       = (SIDE_W > SW) ? SIDE_W : SW;
  localparam int SIDE_CAP = side_cap(MAX_SIDE, MAX_CELLS);
  localparam int QB       = $clog2(SIDE_CAP + 1);
  localparam int KW       = $clog2(QB);
  localparam int DW       = NW + SW;
  localparam int SIDE_RST = side_fit(RESET_SIDE, SIDE_CAP);

  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  logic [SW-1:0]       side_q, side_d;
  logic [NW-1:0]       cells_q, cells_d;
  logic [NW-1:0]       lastrow_q, lastrow_d;
  logic                maze_done_q, maze_done_d;
  logic [AW-1:0]       clr_q, clr_d;
  logic [NW-1:0]       c_q, c_d;
  logic                right_q, right_d;
  logic [NW-1:0]       other_q, other_d;
  logic [DW-1:0]       rem_q, rem_d;
  logic [KW-1:0]       k_q, k_d;
  logic [AW-1:0]       x_q, x_d;
  logic [AW-1:0]       cur_q, cur_d;
  logic [AW-1:0]       ra_q, ra_d;
  logic [AW-1:0]       r1_q, r1_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [WALL_W-1:0]   res_wall_q, res_wall_d;
  logic                res_joined_q, res_joined_d;
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [WALL_W-1:0]   out_wall_q, out_wall_d;
  logic                out_joined_q, out_joined_d;
  logic                byp_q;
  logic [AW-1:0]       byp_data_q;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [AW-1:0] ram_rdata;
  logic [AW-1:0] rd_d;

  logic          in_xfer;
  logic          out_free;
  logic          out_of_range;
  logic          bottom_edge;
  logic [DW-1:0] div_shift;
  logic [DW-1:0] rem_nx;
  logic          div_last;
  logic          find_done;
  logic          root_found;
  logic          same_root;
  logic [NW:0]   dbl_c;

  logic [GW-1:0]   gside;
  logic [SW-1:0]   side_new;
  logic [2*SW-1:0] sq_new;
  logic [NW-1:0]   cells_new;

  // parent memory
  ufmaze_ram #(
    .WIDTH (AW),
    .DEPTH (DEPTH)
  ) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_d = byp_q ? byp_data_q : ram_rdata;

  // config side clamp
  assign gside = GW'(cfg_wdata_i);
  always_comb begin
    if (gside > GW'(SIDE_CAP)) begin
      side_new = SW'(SIDE_CAP);
    end else if (gside < GW'(2)) begin
      side_new = SW'(2);
    end else begin
      side_new = SW'(gside);
    end
  end
  assign sq_new    = {{SW{1'b0}}, side_new} * {{SW{1'b0}}, side_new};
  assign cells_new = NW'(sq_new);

  // shared conditions
  assign in_xfer      = in_valid_i && !in_stall_o;
  assign out_free     = !out_valid_q || !out_stall_i;
  assign out_of_range = (c_q == '0) || (c_q > cells_q);
  assign bottom_edge  = c_q > lastrow_q;
  assign div_shift    = DW'(side_q) << k_q;
  assign rem_nx       = (rem_q >= div_shift) ? (rem_q - div_shift) : rem_q;
  assign div_last     = (k_q == '0);
  assign root_found   = (rd_d == cur_q);
  assign find_done    = ((state_q == ST_FWALK) && root_found && (x_q == cur_q)) ||
                        ((state_q == ST_CWALK) && root_found);
  assign same_root    = (ra_q == cur_q);
  assign dbl_c        = {c_q, 1'b0};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == AW'(MAX_CELLS)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = maze_done_q ? ST_DONE : ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (out_of_range || !right_q) begin
          state_d = ST_FREAD;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_last) begin
          state_d = ST_FREAD;
        end
      end
      ST_FREAD: begin
        state_d = ST_FWALK;
      end
      ST_FWALK, ST_CWALK: begin
        if (find_done) begin
          case (phase_q)
            PH_OTHER: state_d = same_root ? ST_FREAD : ST_LINK;
            PH_LAST:  state_d = ST_DONE;
            default:  state_d = ST_FREAD;
          endcase
        end else if (root_found) begin
          state_d = ST_CWALK;
        end
      end
      ST_LINK: begin
        state_d = ST_FREAD;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (cfg_we_i) begin
      state_d = ST_CLEAR;
    end
  end

  // datapath and memory control
  always_comb begin
    phase_d      = phase_q;
    side_d       = side_q;
    cells_d      = cells_q;
    lastrow_d    = lastrow_q;
    maze_done_d  = maze_done_q;
    clr_d        = clr_q;
    c_d          = c_q;
    right_d      = right_q;
    other_d      = other_q;
    rem_d        = rem_q;
    k_d          = k_q;
    x_d          = x_q;
    cur_d        = cur_q;
    ra_d         = ra_q;
    r1_d         = r1_q;
    res_status_d = res_status_q;
    res_wall_d   = res_wall_q;
    res_joined_d = res_joined_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_wall_d   = out_wall_q;
    out_joined_d = out_joined_q;
    ram_we       = 1'b0;
    ram_waddr    = x_q;
    ram_wdata    = cur_q;
    ram_raddr    = cur_q;

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = clr_q;
        clr_d     = clr_q + AW'(1);
      end
      ST_IDLE: begin
        if (in_xfer) begin
          c_d          = NW'(cell_req_i);
          right_d      = toward_right_i;
          res_wall_d   = '0;
          res_status_d = STAT_DONE;
          res_joined_d = 1'b1;
        end
      end
      ST_CHECK: begin
        if (out_of_range) begin
          res_status_d = STAT_RANGE;
          x_d          = AW'(1);
          cur_d        = AW'(1);
          phase_d      = PH_FIRST;
        end else if (!right_q) begin
          if (bottom_edge) begin
            res_status_d = STAT_EDGE;
            x_d          = AW'(1);
            cur_d        = AW'(1);
            phase_d      = PH_FIRST;
          end else begin
            other_d = c_q + NW'(side_q);
            x_d     = AW'(c_q);
            cur_d   = AW'(c_q);
            phase_d = PH_CELL;
          end
        end else begin
          rem_d = DW'(c_q);
          k_d   = KW'(QB - 1);
        end
      end
      ST_DIV: begin
        rem_d = rem_nx;
        k_d   = k_q - KW'(1);
        if (div_last) begin
          if (rem_nx == '0) begin
            res_status_d = STAT_EDGE;
            x_d          = AW'(1);
            cur_d        = AW'(1);
            phase_d      = PH_FIRST;
          end else begin
            other_d = c_q + NW'(1);
            x_d     = AW'(c_q);
            cur_d   = AW'(c_q);
            phase_d = PH_CELL;
          end
        end
      end
      ST_FWALK, ST_CWALK: begin
        if (state_q == ST_CWALK) begin
          // compress: point the node on the path at the root
          ram_we    = 1'b1;
          ram_waddr = x_q;
          ram_wdata = cur_q;
        end
        if (find_done) begin
          case (phase_q)
            PH_CELL: begin
              ra_d    = cur_q;
              x_d     = AW'(other_q);
              cur_d   = AW'(other_q);
              phase_d = PH_OTHER;
            end
            PH_OTHER: begin
              phase_d = PH_FIRST;
              if (same_root) begin
                res_status_d = STAT_JOINED;
                x_d          = AW'(1);
                cur_d        = AW'(1);
              end else begin
                res_status_d = STAT_REMOVED;
                res_wall_d   = WALL_W'(dbl_c - (NW + 1)'(right_q));
              end
            end
            PH_FIRST: begin
              r1_d    = cur_q;
              x_d     = AW'(cells_q);
              cur_d   = AW'(cells_q);
              phase_d = PH_LAST;
            end
            default: begin
              res_joined_d = (r1_q == cur_q);
            end
          endcase
        end else if (state_q == ST_CWALK) begin
          x_d       = rd_d;
          ram_raddr = rd_d;
        end else if (root_found) begin
          ram_raddr = x_q;
        end else begin
          cur_d     = rd_d;
          ram_raddr = rd_d;
        end
      end
      ST_LINK: begin
        // root of the cell goes under the root of its neighbor
        ram_we    = 1'b1;
        ram_waddr = ra_q;
        ram_wdata = cur_q;
        x_d       = AW'(1);
        cur_d     = AW'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_wall_d   = res_wall_q;
          out_joined_d = res_joined_q;
          maze_done_d  = maze_done_q || res_joined_q;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase

    if (cfg_we_i) begin
      side_d      = side_new;
      cells_d     = cells_new;
      lastrow_d   = cells_new - NW'(side_new);
      maze_done_d = 1'b0;
      clr_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      phase_q     <= PH_CELL;
      side_q      <= SW'(SIDE_RST);
      cells_q     <= NW'(SIDE_RST * SIDE_RST);
      lastrow_q   <= NW'(SIDE_RST * (SIDE_RST - 1));
      maze_done_q <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      byp_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      side_q      <= side_d;
      cells_q     <= cells_d;
      lastrow_q   <= lastrow_d;
      maze_done_q <= maze_done_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      byp_q       <= ram_we && (ram_waddr == ram_raddr);
    end
  end

  always_ff @(posedge clk_i) begin
    c_q          <= c_d;
    right_q      <= right_d;
    other_q      <= other_d;
    rem_q        <= rem_d;
    k_q          <= k_d;
    x_q          <= x_d;
    cur_q        <= cur_d;
    ra_q         <= ra_d;
    r1_q         <= r1_d;
    res_status_q <= res_status_d;
    res_wall_q   <= res_wall_d;
    res_joined_q <= res_joined_d;
    out_status_q <= out_status_d;
    out_wall_q   <= out_wall_d;
    out_joined_q <= out_joined_d;
    byp_data_q   <= ram_wdata;
  end

  assign in_stall_o         = (state_q != ST_IDLE);
  assign out_valid_o        = out_valid_q;
  assign status_o           = out_status_q;
  assign wall_index_o       = out_wall_q;
  assign start_end_joined_o = out_joined_q;

  `UFM_ASSERT(a_wall_only_removed, !(out_valid_o && status_o != STAT_REMOVED) || wall_index_o == '0)
  `UFM_ASSERT(a_walk_nonzero, !(state_q == ST_FWALK || state_q == ST_CWALK) || cur_q != '0)
  `UFM_ASSERT_NEXT(a_done_sticky, maze_done_q && !cfg_we_i, maze_done_q)

endmodule
